FILE: src/c7s_pkg.sv
`timescale 1ns / 1ps
package c7s_pkg;
  localparam int KS    = 7;
  localparam int TAPS  = KS * KS;
  localparam int LINES = KS - 1;
  localparam int PIX_W = 16;
  localparam int ACC_W = 40;
  localparam int PROD_W = 32;

  localparam logic OP_COEF  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_BIAS  = 1'b1;

  typedef logic signed [PIX_W-1:0] pix_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [LINES*PIX_W-1:0] line_word_t;
endpackage

FILE: src/conv7x7_stride1_stream_top.sv
`timescale 1ns / 1ps
// 7x7 valid convolution at stride 1 over a raster pixel stream.
// Input channel in_*: tuser is op (0 = coefficient load, 1 = pixel);
// tdata carries pixel, frame_start, coef_index, coef_value.
// Output channel out_*: tdata carries conv_sum, out_column, out_row;
// tlast is row_last, set on the last output of each output row.
// Configuration channel cfg_*: index 0 is image_width, index 1 is bias.
// Throughput: one item per cycle while in_tready is high. The six previous
// rows sit in one wide line memory (one word per column); each pixel reads
// its column and writes it back in the following cycle, with forwarding when
// consecutive pixels hit the same column (narrow clamped width is not possible,
// but the same column repeats at frame wrap with width clamping).
// Path: each output passes through memory read, window shift, snapshot,
// products, row sums, final sum and the output FIFO.
// The pipeline never stalls; results land in a 16-entry output FIFO and
// in_tready drops while the FIFO and the pipeline hold 15 items between them.
// Reset: line memory clears in a pass over all MAX_WIDTH addresses during
// which no input item is accepted; kernel, window and counters clear at once.
module conv7x7_stride1_stream_top
  import c7s_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // pixel[15:0], frame_start[16], coef_index[22:17],
                                  // coef_value[38:23], zero[39]
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // conv_sum[39:0], out_column[49:40], out_row[61:50]
  output logic        out_tlast,  // row_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [39:0] cfg_data
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int NST = 6;

  logic [10:0] width_r;
  acc_t        bias_r;
  pix_t        kern_r [TAPS];
  pix_t        win_r  [TAPS];

  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic          clr_r;
  logic [AW-1:0] clr_addr_r;

  logic [NST-1:0] vld_r;
  logic           room;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 11'd14;
      bias_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIDTH: width_r <= cfg_data[10:0];
        CFG_BIAS:  bias_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = !clr_r && room;

  logic in_acc, pix_acc;
  assign in_acc  = in_tvalid && in_tready;
  assign pix_acc = in_acc && (in_tuser == OP_PIXEL);

  pix_t          in_pixel;
  logic          in_fs;
  logic [5:0]    in_cidx;
  pix_t          in_cval;
  assign in_pixel = in_tdata[15:0];
  assign in_fs    = in_tdata[16];
  assign in_cidx  = in_tdata[22:17];
  assign in_cval  = in_tdata[38:23];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) kern_r[i] <= '0;
    end else if (in_acc && in_tuser == OP_COEF && in_cidx < 6'(TAPS)) begin
      kern_r[in_cidx] <= in_cval;
    end
  end

  // stage 0: counters, memory read address
  logic [CW-1:0] eff_w;
  always_comb begin
    if (32'(width_r) < 32'(KS)) eff_w = CW'(KS);
    else if (32'(width_r) > 32'(MAX_WIDTH)) eff_w = CW'(MAX_WIDTH);
    else eff_w = CW'(width_r);
  end

  logic [CW-1:0] col_c;
  logic [RW-1:0] row_c;
  logic          last_c, emit_c;
  always_comb begin
    col_c = in_fs ? '0 : col_r;
    row_c = in_fs ? '0 : row_r;
    if (col_c >= eff_w) col_c = eff_w - CW'(1);
    last_c = (col_c + CW'(1) == eff_w);
    emit_c = (col_c >= CW'(KS - 1)) && (row_c >= RW'(KS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      clr_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(MAX_WIDTH - 1)) clr_r <= 1'b0;
      end
      if (pix_acc) begin
        if (last_c) begin
          col_r <= '0;
          if (row_c != RW'(MAX_HEIGHT - 1)) row_r <= row_c + RW'(1);
          else row_r <= row_c;
        end else begin
          col_r <= col_c + CW'(1);
          row_r <= row_c;
        end
      end
    end
  end

  // stage 1: memory data arrives, write back shifted column
  logic          s1_v_r;
  logic [AW-1:0] s1_addr_r;
  pix_t          s1_pix_r;
  logic          s1_emit_r, s1_last_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;
  line_word_t    rd_word, col_word, wr_word;
  logic          we;
  logic [AW-1:0] waddr;

  c7s_ram #(.WIDTH(LINES * PIX_W), .DEPTH(MAX_WIDTH)) u_line (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_word),
    .raddr (col_c[AW-1:0]),
    .rdata (rd_word)
  );

  // forward when the previous pixel wrote the column now read
  logic          fwd_r;
  line_word_t    fwd_word_r;
  always_ff @(posedge clk) begin
    fwd_r      <= pix_acc && s1_v_r && (col_c[AW-1:0] == s1_addr_r);
    fwd_word_r <= wr_word;
  end
  assign col_word = fwd_r ? fwd_word_r : rd_word;
  // line r holds column[r]; shift down and insert the new pixel on top
  assign wr_word = clr_r ? '0 : {s1_pix_r, col_word[LINES*PIX_W-1:PIX_W]};
  assign we      = clr_r || s1_v_r;
  assign waddr   = clr_r ? clr_addr_r : s1_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= pix_acc;
    end
    s1_addr_r <= col_c[AW-1:0];
    s1_pix_r  <= in_pixel;
    s1_emit_r <= emit_c;
    s1_last_r <= last_c;
    s1_col_r  <= col_c;
    s1_row_r  <= row_c;
  end

  // window shift at stage 1; snapshot window into product stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) win_r[i] <= '0;
    end else if (s1_v_r) begin
      for (int r = 0; r < KS; r++) begin
        for (int c = 0; c < KS - 1; c++) win_r[r*KS+c] <= win_r[r*KS+c+1];
        if (r < LINES) win_r[r*KS+KS-1] <= col_word[r*PIX_W +: PIX_W];
        else win_r[r*KS+KS-1] <= s1_pix_r;
      end
    end
  end

  // stage 2: carry valid and output indices toward the snapshot
  logic          s2_v_r;
  logic          s2_last_r;
  logic [9:0]    s2_ocol_r;
  logic [11:0]   s2_orow_r;
  pix_t          k1_r [TAPS];
  pix_t          snap_r [TAPS];
  pix_t          ksnap_r [TAPS];
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else s2_v_r <= s1_v_r && s1_emit_r;
    s2_last_r <= s1_last_r;
    s2_ocol_r <= 10'(s1_col_r - CW'(KS - 1));
    s2_orow_r <= 12'(s1_row_r - RW'(KS - 1));
  end
  // window updates at end of stage 1 cycle, so copy it now; hold the kernel
  // as it was at stage 1 so a later coefficient load cannot reach this pixel
  always_ff @(posedge clk) begin
    for (int i = 0; i < TAPS; i++) begin
      k1_r[i]    <= kern_r[i];
      snap_r[i]  <= win_r[i];
      ksnap_r[i] <= k1_r[i];
    end
  end
  // snap_r/ksnap_r are registered after stage 2: realign via the s3 valid delay
  logic          s3_v_r, s3_last_r;
  logic [9:0]    s3_ocol_r;
  logic [11:0]   s3_orow_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else s3_v_r <= s2_v_r;
    s3_last_r <= s2_last_r;
    s3_ocol_r <= s2_ocol_r;
    s3_orow_r <= s2_orow_r;
  end

  // 49 products in parallel lanes, registered
  logic signed [PROD_W-1:0] prod_r [TAPS];
  logic          s4_v_r, s4_last_r;
  logic [9:0]    s4_ocol_r;
  logic [11:0]   s4_orow_r;
  always_ff @(posedge clk) begin
    for (int i = 0; i < TAPS; i++) prod_r[i] <= snap_r[i] * ksnap_r[i];
    if (!rst_n) s4_v_r <= 1'b0;
    else s4_v_r <= s3_v_r;
    s4_last_r <= s3_last_r;
    s4_ocol_r <= s3_ocol_r;
    s4_orow_r <= s3_orow_r;
  end

  // adder tree: rows of 7, then 7 row sums plus bias
  acc_t rsum_r [KS];
  logic          s5_v_r, s5_last_r;
  logic [9:0]    s5_ocol_r;
  logic [11:0]   s5_orow_r;
  always_ff @(posedge clk) begin
    for (int r = 0; r < KS; r++) begin
      acc_t t;
      t = '0;
      for (int c = 0; c < KS; c++) t = t + ACC_W'(prod_r[r*KS+c]);
      rsum_r[r] <= t;
    end
    if (!rst_n) s5_v_r <= 1'b0;
    else s5_v_r <= s4_v_r;
    s5_last_r <= s4_last_r;
    s5_ocol_r <= s4_ocol_r;
    s5_orow_r <= s4_orow_r;
  end

  acc_t          sum_r;
  logic          s6_v_r, s6_last_r;
  logic [9:0]    s6_ocol_r;
  logic [11:0]   s6_orow_r;
  always_ff @(posedge clk) begin
    acc_t t;
    t = bias_r;
    for (int r = 0; r < KS; r++) t = t + rsum_r[r];
    sum_r <= t;
    if (!rst_n) s6_v_r <= 1'b0;
    else s6_v_r <= s5_v_r;
    s6_last_r <= s5_last_r;
    s6_ocol_r <= s5_ocol_r;
    s6_orow_r <= s5_orow_r;
  end

  assign vld_r = {s6_v_r, s5_v_r, s4_v_r, s3_v_r, s2_v_r, s1_v_r};

  // output FIFO absorbs in-flight results while the receiver stalls
  localparam int FD = 16;
  logic [62:0] fifo_r [FD];
  logic [3:0]  wp_r, rp_r;
  logic [4:0]  cnt_r;
  logic        pop;
  assign pop = out_tvalid && out_tready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (s6_v_r) wp_r <= wp_r + 4'd1;
      if (pop) rp_r <= rp_r + 4'd1;
      cnt_r <= cnt_r + 5'(s6_v_r) - 5'(pop);
    end
    if (s6_v_r) fifo_r[wp_r] <= {s6_last_r, s6_orow_r, s6_ocol_r, sum_r};
  end

  // admit only while the FIFO can hold every item in flight
  assign room = (5'($countones(vld_r)) + cnt_r) < 5'(FD - 1);

  assign out_tvalid = cnt_r != 5'd0;
  assign out_tdata  = {2'b0, fifo_r[rp_r][61:0]};
  assign out_tlast  = fifo_r[rp_r][62];
endmodule

FILE: src/c7s_ram.sv
`timescale 1ns / 1ps
module c7s_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/c7s_checker.sv
`timescale 1ns / 1ps
module c7s_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tlast
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable({out_tlast, out_tdata}))
    else $error("output item dropped while stalled");
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[63:62] == 2'b00)
    else $error("output padding not zero");
  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready during line clear");
endmodule

bind conv7x7_stride1_stream_top c7s_checker u_c7s_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);
